[src/pso_pkg.sv]
// Package for the polyline stroke offset block: field widths, derived
// arithmetic widths, register indexes and the normal unit's request types.
// Used by every other file of the block; depends on nothing.
package pso_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int WIDTH_BITS = 12;

  // Normal arithmetic: magnitudes are brought below 2^MAG_BITS, the
  // normal is Q.FRAC_BITS and the radicand is scaled by 2^SCALE_BITS
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = 15;
  localparam int FRAC_BITS  = 14;
  localparam int SCALE_BITS = 2 * FRAC_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS + 1;
  localparam int RAD_BITS   = SQ_BITS + SCALE_BITS;
  localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
  localparam int NUM_BITS   = MAG_BITS + SCALE_BITS + 1;
  localparam int QUOT_BITS  = FRAC_BITS + 1;
  localparam int OFF_BITS   = WIDTH_BITS + 1;
  localparam int SUM_BITS   = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 2;

  // Configuration registers
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_MODE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_WIDTH = CFG_IDX_BITS'(1);
  localparam logic [WIDTH_BITS-1:0]   FIXED_WIDTH_RST = WIDTH_BITS'(160);

  // Request to the normal unit: direction difference and half-width
  typedef struct packed {
    logic [DIFF_BITS-1:0]  dx;
    logic [DIFF_BITS-1:0]  dy;
    logic [WIDTH_BITS-1:0] w;
  } norm_req_t;

  // Signed offset returned by the normal unit
  typedef struct packed {
    logic [OFF_BITS-1:0] off_x;
    logic [OFF_BITS-1:0] off_y;
  } norm_rsp_t;

endpackage

[src/pso_if.sv]
// Channel interfaces of the polyline stroke offset block: vertex input
// and strip point pair output, each with valid/ready. Depends on pso_pkg.
interface pso_in_if;
  logic                             valid;
  logic                             ready;
  logic [pso_pkg::COORD_BITS-1:0]   x_pos;
  logic [pso_pkg::COORD_BITS-1:0]   y_pos;
  logic [pso_pkg::WIDTH_BITS-1:0]   vertex_width;
  logic                             last_vertex;

  modport source (output valid, x_pos, y_pos, vertex_width, last_vertex, input ready);
  modport sink   (input valid, x_pos, y_pos, vertex_width, last_vertex, output ready);
endinterface

interface pso_out_if;
  logic                             valid;
  logic                             ready;
  logic [pso_pkg::COORD_BITS-1:0]   left_x;
  logic [pso_pkg::COORD_BITS-1:0]   left_y;
  logic [pso_pkg::COORD_BITS-1:0]   right_x;
  logic [pso_pkg::COORD_BITS-1:0]   right_y;
  logic                             last_pair;

  modport source (output valid, left_x, left_y, right_x, right_y, last_pair, input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, last_pair, output ready);
endinterface

[src/pso_sqrt.sv]
// Bit-serial integer square root: one root bit per cycle, radicand is the
// sum of squares scaled by 2^SCALE_BITS. Depends on pso_pkg.
module pso_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pso_pkg::SQ_BITS-1:0]   sq,
  output logic                          done,
  output logic [pso_pkg::ROOT_BITS-1:0] root
);

  localparam int RB    = pso_pkg::ROOT_BITS;
  localparam int RAD_W = 2 * RB;
  localparam int REM_W = RB + 2;
  localparam int CNT_W = $clog2(RB + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [RB-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [REM_W+1:0] rem_sh, trial;
  logic             ge;

  // Bring down two radicand bits, try the next root bit
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W + 2)'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'({sq, {pso_pkg::SCALE_BITS{1'b0}}});
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(RB);
    end else if (cnt_r != '0) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = REM_W'(ge ? (rem_sh - trial) : rem_sh);
      root_nxt = {root_r[RB-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Hold control under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/pso_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, quotient known
// to fit QUOT_BITS. Depends on pso_pkg.
module pso_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pso_pkg::NUM_BITS-1:0]  num,
  input  logic [pso_pkg::ROOT_BITS-1:0] den,
  output logic                          done,
  output logic [pso_pkg::QUOT_BITS-1:0] quot
);

  localparam int NW    = pso_pkg::NUM_BITS;
  localparam int QW    = pso_pkg::QUOT_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    dsh_r, dsh_nxt;
  logic [QW-1:0]    quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  // Compare against the shifted divisor, subtract on a one bit
  always_comb begin
    ge       = (rem_r >= dsh_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NW'({den, {(QW-1){1'b0}}});
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt  = dsh_r >> 1;
      quot_nxt = {quot_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[src/pso_norm.sv]
// Normal offset unit: turns a direction difference and half-width into the
// signed offset (unit normal times width). Depends on pso_pkg, pso_sqrt, pso_div.
module pso_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pso_pkg::norm_req_t req,
  output logic               done,
  output pso_pkg::norm_rsp_t rsp
);

  localparam int DW    = pso_pkg::DIFF_BITS;
  localparam int MW    = pso_pkg::MAG_BITS;
  localparam int QW    = pso_pkg::QUOT_BITS;
  localparam int WW    = pso_pkg::WIDTH_BITS;
  localparam int MUL_A = (MW > QW) ? MW : QW;
  localparam int MUL_B = (MW > WW) ? MW : WW;
  localparam int RND_W = MUL_A + MUL_B + 1;
  localparam logic [QW-1:0]    ONE  = QW'(1) << pso_pkg::FRAC_BITS;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (pso_pkg::FRAC_BITS - 1);

  typedef enum logic [8:0] {
    N_IDLE  = 9'b000000001,
    N_SHIFT = 9'b000000010,
    N_SQX   = 9'b000000100,
    N_SQY   = 9'b000001000,
    N_ROOT  = 9'b000010000,
    N_DIVX  = 9'b000100000,
    N_DIVY  = 9'b001000000,
    N_MULX  = 9'b010000000,
    N_MULY  = 9'b100000000
  } norm_state_t;

  norm_state_t               st_r, st_nxt;
  logic [DW-1:0]             ax_r, ax_nxt, ay_r, ay_nxt;
  logic [WW-1:0]             w_r, w_nxt;
  logic                      flip_x_r, flip_x_nxt, flip_y_r, flip_y_nxt;
  logic [pso_pkg::SQ_BITS-1:0] sq_r, sq_nxt;
  logic [QW-1:0]             mx_r, mx_nxt, my_r, my_nxt;
  logic [WW-1:0]             magx_r, magx_nxt, magy_r, magy_nxt;
  logic                      sq_start_r, sq_start_nxt;
  logic                      dv_start_r, dv_start_nxt;
  logic                      done_r, done_nxt;

  logic [MW-1:0]             ax_m, ay_m;
  logic                      big;
  logic [MUL_A-1:0]          mul_a;
  logic [MUL_B-1:0]          mul_b;
  logic [MUL_A+MUL_B-1:0]    prod;
  logic [RND_W-1:0]          rnd;
  logic [WW-1:0]             mag_rnd;
  logic [QW-1:0]             q_clamp;
  logic                      sq_done, dv_done;
  logic [pso_pkg::ROOT_BITS-1:0] root;
  logic [pso_pkg::NUM_BITS-1:0]  dv_num;
  logic [QW-1:0]             quot;
  logic [pso_pkg::OFF_BITS-1:0]  ext_x, ext_y;

  pso_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .sq    (sq_r),
    .done  (sq_done),
    .root  (root)
  );

  // Numerator: magnitude scaled, plus half the length for rounding
  assign dv_num = pso_pkg::NUM_BITS'({(st_r == N_DIVY) ? ax_m : ay_m,
                                      {pso_pkg::SCALE_BITS{1'b0}}})
                + pso_pkg::NUM_BITS'(root >> 1);

  pso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start_r),
    .num   (dv_num),
    .den   (root),
    .done  (dv_done),
    .quot  (quot)
  );

  // Shared multiplier: squares first, then normal times width
  always_comb begin
    ax_m    = MW'(ax_r);
    ay_m    = MW'(ay_r);
    big     = ((64'(ax_r) >> MW) != 64'd0) || ((64'(ay_r) >> MW) != 64'd0);
    mul_a   = '0;
    mul_b   = '0;
    case (st_r)
      N_SQX:   begin mul_a = MUL_A'(ax_m); mul_b = MUL_B'(ax_m); end
      N_SQY:   begin mul_a = MUL_A'(ay_m); mul_b = MUL_B'(ay_m); end
      N_MULX:  begin mul_a = MUL_A'(mx_r); mul_b = MUL_B'(w_r);  end
      N_MULY:  begin mul_a = MUL_A'(my_r); mul_b = MUL_B'(w_r);  end
      default: begin mul_a = '0;           mul_b = '0;           end
    endcase
    prod    = mul_a * mul_b;
    rnd     = RND_W'(prod) + HALF;
    mag_rnd = WW'(rnd >> pso_pkg::FRAC_BITS);
    q_clamp = (quot > ONE) ? ONE : quot;
  end

  // Sequencer
  always_comb begin
    st_nxt       = st_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    w_nxt        = w_r;
    flip_x_nxt   = flip_x_r;
    flip_y_nxt   = flip_y_r;
    sq_nxt       = sq_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    magx_nxt     = magx_r;
    magy_nxt     = magy_r;
    sq_start_nxt = 1'b0;
    dv_start_nxt = 1'b0;
    done_nxt     = 1'b0;
    unique case (st_r)
      N_IDLE: begin
        if (start) begin
          ax_nxt     = req.dx[DW-1] ? DW'(-req.dx) : req.dx;
          ay_nxt     = req.dy[DW-1] ? DW'(-req.dy) : req.dy;
          w_nxt      = req.w;
          flip_x_nxt = !req.dy[DW-1] && (req.dy != '0);
          flip_y_nxt = req.dx[DW-1];
          if (req.dx == '0 && req.dy == '0) begin
            // zero difference: normal points straight up
            magx_nxt   = '0;
            magy_nxt   = req.w;
            flip_x_nxt = 1'b0;
            flip_y_nxt = 1'b0;
            done_nxt   = 1'b1;
          end else begin
            st_nxt = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        if (big) begin
          ax_nxt = ax_r >> 1;
          ay_nxt = ay_r >> 1;
        end else begin
          st_nxt = N_SQX;
        end
      end
      N_SQX: begin
        sq_nxt = pso_pkg::SQ_BITS'(prod);
        st_nxt = N_SQY;
      end
      N_SQY: begin
        sq_nxt       = sq_r + pso_pkg::SQ_BITS'(prod);
        sq_start_nxt = 1'b1;
        st_nxt       = N_ROOT;
      end
      N_ROOT: begin
        if (sq_done) begin
          dv_start_nxt = 1'b1;
          st_nxt       = N_DIVX;
        end
      end
      N_DIVX: begin
        if (dv_done) begin
          mx_nxt       = q_clamp;
          dv_start_nxt = 1'b1;
          st_nxt       = N_DIVY;
        end
      end
      N_DIVY: begin
        if (dv_done) begin
          my_nxt = q_clamp;
          st_nxt = N_MULX;
        end
      end
      N_MULX: begin
        magx_nxt = mag_rnd;
        st_nxt   = N_MULY;
      end
      N_MULY: begin
        magy_nxt = mag_rnd;
        done_nxt = 1'b1;
        st_nxt   = N_IDLE;
      end
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= N_IDLE;
      sq_start_r <= 1'b0;
      dv_start_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      sq_start_r <= sq_start_nxt;
      dv_start_r <= dv_start_nxt;
      done_r     <= done_nxt;
    end
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    w_r      <= w_nxt;
    flip_x_r <= flip_x_nxt;
    flip_y_r <= flip_y_nxt;
    sq_r     <= sq_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    magx_r   <= magx_nxt;
    magy_r   <= magy_nxt;
  end

  // Apply signs after rounding
  assign ext_x     = pso_pkg::OFF_BITS'(magx_r);
  assign ext_y     = pso_pkg::OFF_BITS'(magy_r);
  assign rsp.off_x = flip_x_r ? -ext_x : ext_x;
  assign rsp.off_y = flip_y_r ? -ext_y : ext_y;
  assign done      = done_r;

endmodule

[src/polyline_stroke_offset_top.sv]
// Top level of the polyline stroke offset block: vertex history, pair
// sequencing, saturation and the output register.
// Depends on pso_pkg, pso_if (pso_in_if, pso_out_if) and pso_norm.
//
//  Port       | Dir | Transfer                       | Payload
//  -----------+-----+--------------------------------+------------------------------
//  in_vtx     | in  | valid & ready                  | x_pos, y_pos, vertex_width,
//             |     |                                | last_vertex
//  out_pair   | out | valid & ready                  | left_x/y, right_x/y, last_pair
//  cfg_*      | in  | cfg_we (no wait, no read-back) | cfg_idx, cfg_data
//
// One vertex is worked on at a time. Each pair goes through any scaling
// shift, the bit-serial square root and the two divisions before
// out_pair.valid; a pair with zero direction skips them.
// A last vertex after a held one gives two pairs.
// Reset (rst_n, synchronous) empties the history and restores registers.
// A stalled output holds the finished pair; the next pair waits behind it.
module polyline_stroke_offset_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pso_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [pso_pkg::WIDTH_BITS-1:0]    cfg_data,
  pso_in_if.sink                            in_vtx,
  pso_out_if.source                         out_pair
);

  localparam int CW = pso_pkg::COORD_BITS;
  localparam int WW = pso_pkg::WIDTH_BITS;
  localparam int SW = pso_pkg::SUM_BITS;
  localparam logic [1:0] HC_NONE  = 2'd0;
  localparam logic [1:0] HC_FIRST = 2'd1;
  localparam logic [1:0] HC_LATER = 2'd2;
  localparam longint SAT_HI_L = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-SAT_HI_L - 64'sd1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_PUT  = 3'b100
  } top_state_t;

  top_state_t     st_r, st_nxt;
  logic           width_mode_r, width_mode_nxt;
  logic [WW-1:0]  fixed_width_r, fixed_width_nxt;
  logic [CW-1:0]  older_x_r, older_x_nxt, older_y_r, older_y_nxt;
  logic [CW-1:0]  held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  logic [WW-1:0]  held_w_r, held_w_nxt;
  logic [1:0]     held_count_r, held_count_nxt;
  logic [CW-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [WW-1:0]  cur_w_r, cur_w_nxt;
  logic           cur_last_r, cur_last_nxt;
  logic           sel_r, sel_nxt;
  logic           start_r, start_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  lx_r, lx_nxt, ly_r, ly_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic           lp_r, lp_nxt;

  logic           in_xfer, out_free, held_any;
  logic [WW-1:0]  w_sel;
  logic [CW-1:0]  vx, vy, px, py;
  logic [WW-1:0]  jw;
  pso_pkg::norm_req_t req;
  pso_pkg::norm_rsp_t rsp;
  logic           norm_done;
  logic signed [SW-1:0] sum_lx, sum_ly, sum_rx, sum_ry;

  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return CW'(c);
  endfunction

  // Pick the vertex, its neighbours and width for the current pair
  always_comb begin
    held_any = (held_count_r != HC_NONE);
    vx  = sel_r ? cur_x_r : held_x_r;
    vy  = sel_r ? cur_y_r : held_y_r;
    px  = sel_r ? (held_any ? held_x_r : cur_x_r) : older_x_r;
    py  = sel_r ? (held_any ? held_y_r : cur_y_r) : older_y_r;
    jw  = sel_r ? cur_w_r : held_w_r;
    req.dx = pso_pkg::DIFF_BITS'($signed(cur_x_r)) - pso_pkg::DIFF_BITS'($signed(px));
    req.dy = pso_pkg::DIFF_BITS'($signed(cur_y_r)) - pso_pkg::DIFF_BITS'($signed(py));
    req.w  = jw;
  end

  pso_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .req   (req),
    .done  (norm_done),
    .rsp   (rsp)
  );

  // Offset the vertex both ways
  always_comb begin
    sum_lx = SW'($signed(vx)) + SW'($signed(rsp.off_x));
    sum_ly = SW'($signed(vy)) + SW'($signed(rsp.off_y));
    sum_rx = SW'($signed(vx)) - SW'($signed(rsp.off_x));
    sum_ry = SW'($signed(vy)) - SW'($signed(rsp.off_y));
  end

  assign in_vtx.ready = (st_r == S_IDLE) && !start_r;
  assign in_xfer      = in_vtx.valid && in_vtx.ready;
  assign out_free     = !out_valid_r || out_pair.ready;
  assign w_sel        = width_mode_r ? in_vtx.vertex_width : fixed_width_r;

  // Configuration writes
  always_comb begin
    width_mode_nxt  = width_mode_r;
    fixed_width_nxt = fixed_width_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        pso_pkg::REG_WIDTH_MODE:  width_mode_nxt  = cfg_data[0];
        pso_pkg::REG_FIXED_WIDTH: fixed_width_nxt = cfg_data;
        default:                  width_mode_nxt  = width_mode_r;
      endcase
    end
  end

  // Sequence the pairs of one vertex and advance the history
  always_comb begin
    st_nxt         = st_r;
    older_x_nxt    = older_x_r;
    older_y_nxt    = older_y_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_w_nxt     = held_w_r;
    held_count_nxt = held_count_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cur_w_nxt      = cur_w_r;
    cur_last_nxt   = cur_last_r;
    sel_nxt        = sel_r;
    start_nxt      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_pair.ready;
    lx_nxt         = lx_r;
    ly_nxt         = ly_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    lp_nxt         = lp_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          cur_x_nxt    = in_vtx.x_pos;
          cur_y_nxt    = in_vtx.y_pos;
          cur_w_nxt    = w_sel;
          cur_last_nxt = in_vtx.last_vertex;
          if (held_count_r != HC_NONE) begin
            sel_nxt   = 1'b0;
            start_nxt = 1'b1;
            st_nxt    = S_RUN;
          end else if (in_vtx.last_vertex) begin
            sel_nxt   = 1'b1;
            start_nxt = 1'b1;
            st_nxt    = S_RUN;
          end else begin
            older_x_nxt    = in_vtx.x_pos;
            older_y_nxt    = in_vtx.y_pos;
            held_x_nxt     = in_vtx.x_pos;
            held_y_nxt     = in_vtx.y_pos;
            held_w_nxt     = w_sel;
            held_count_nxt = HC_FIRST;
          end
        end
      end
      S_RUN: begin
        if (norm_done) st_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          lx_nxt        = sat(sum_lx);
          ly_nxt        = sat(sum_ly);
          rx_nxt        = sat(sum_rx);
          ry_nxt        = sat(sum_ry);
          lp_nxt        = sel_r;
          if (!sel_r && cur_last_r) begin
            sel_nxt   = 1'b1;
            start_nxt = 1'b1;
            st_nxt    = S_RUN;
          end else if (cur_last_r) begin
            // polyline closed: drop the history
            older_x_nxt    = '0;
            older_y_nxt    = '0;
            held_x_nxt     = '0;
            held_y_nxt     = '0;
            held_w_nxt     = '0;
            held_count_nxt = HC_NONE;
            st_nxt         = S_IDLE;
          end else begin
            older_x_nxt    = held_x_r;
            older_y_nxt    = held_y_r;
            held_x_nxt     = cur_x_r;
            held_y_nxt     = cur_y_r;
            held_w_nxt     = cur_w_r;
            held_count_nxt = HC_LATER;
            st_nxt         = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      width_mode_r  <= 1'b0;
      fixed_width_r <= pso_pkg::FIXED_WIDTH_RST;
      older_x_r     <= '0;
      older_y_r     <= '0;
      held_x_r      <= '0;
      held_y_r      <= '0;
      held_w_r      <= '0;
      held_count_r  <= HC_NONE;
      start_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      width_mode_r  <= width_mode_nxt;
      fixed_width_r <= fixed_width_nxt;
      older_x_r     <= older_x_nxt;
      older_y_r     <= older_y_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
      held_w_r      <= held_w_nxt;
      held_count_r  <= held_count_nxt;
      start_r       <= start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    cur_w_r    <= cur_w_nxt;
    cur_last_r <= cur_last_nxt;
    sel_r      <= sel_nxt;
    lx_r       <= lx_nxt;
    ly_r       <= ly_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    lp_r       <= lp_nxt;
  end

  assign out_pair.valid     = out_valid_r;
  assign out_pair.left_x    = lx_r;
  assign out_pair.left_y    = ly_r;
  assign out_pair.right_x   = rx_r;
  assign out_pair.right_y   = ry_r;
  assign out_pair.last_pair = lp_r;

endmodule
